@@ rtl/core/pdh_pkg.sv @@
// Shared types and constants for the pair distance histogram core.
package pdh_pkg;

  localparam int COORD_BITS        = 24;
  localparam int RADIUS_W          = 23;
  localparam int BINS_W            = 7;
  localparam int CFG_W             = 23;
  localparam int COUNT_W           = 32;
  localparam int BIN_NUM_W         = 6;
  localparam int DEF_WINDOW_DEPTH  = 1024;
  localparam int DEF_MAX_BINS      = 64;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(256);
  localparam logic [BINS_W-1:0]   BINS_RESET   = BINS_W'(32);
  localparam logic [COUNT_W-1:0]  PAIR_INC     = COUNT_W'(2);
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  // configuration register indexes
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_BINS   = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic                         final_point;
  } in_item_t;

  typedef struct packed {
    logic [BIN_NUM_W-1:0] bin_number;
    logic [COUNT_W-1:0]   bin_count;
    logic                 window_overflowed;
    logic                 last_bin;
  } out_item_t;

endpackage

@@ rtl/core/pdh_window_ram.sv @@
// Ring window store of point coordinates: one write port, one registered read port.
module pdh_window_ram
  import pdh_pkg::*;
#(
  parameter int DEPTH = DEF_WINDOW_DEPTH,
  parameter int AW    = $clog2(DEF_WINDOW_DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic signed [COORD_BITS-1:0] wx,
  input  logic signed [COORD_BITS-1:0] wy,
  input  logic [AW-1:0]                raddr,
  output logic signed [COORD_BITS-1:0] rx,
  output logic signed [COORD_BITS-1:0] ry
);

  logic signed [COORD_BITS-1:0] mem_x [DEPTH];
  logic signed [COORD_BITS-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

@@ rtl/core/pair_distance_histogram_core.sv @@
// Top level of the pair distance histogram core: sequencer, shared arithmetic, histogram.
//
// Usage: write radius (index 0) and bins_in_use (index 1) on the cfg port while idle.
// Send points, sorted by x, on the in_* request channel. Each point first evicts
// window entries whose x lies left of x - radius (states S_EV_RD and S_EV_CHK
// each), then is paired with every windowed point. An out-of-range pair passes
// S_PR_RD, S_PR_MX, S_PR_MY and S_PR_SUM; an in-range pair adds an integer square
// root, a multiply by the bin count and a restoring divide by the radius, and a
// histogram read-modify-write. The shared multiplier and the single window read
// port serialise this work, with in_ready low while a point is processed.
// On a point with final_point set, each bin in use leaves on the out_* channel, in
// order, through S_RO_RD, S_RO_LD and S_RO_WAIT; a stalled receiver holds the
// output register and the readout waits. After the last bin is taken the histogram,
// window and overflow flag clear together. Reset clears control state, sets the
// registers to radius 256 and 32 bins and empties window and histogram.
module pair_distance_histogram_core
  import pdh_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int MAX_BINS     = DEF_MAX_BINS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW      = $clog2(WINDOW_DEPTH);
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int MUL_W   = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
  localparam int P_W     = 2 * MUL_W;
  localparam int D2_W    = P_W + 1;
  localparam int SQ_N    = (D2_W + 1) / 2;
  localparam int SQ_OP_W = 2 * SQ_N;
  localparam int STEP_W  = $clog2(SQ_N + 1);
  localparam int NB_W    = $clog2(MAX_BINS + 1);
  localparam int BIN_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int XL_W    = MUL_W + 2;

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_R2      = 18'h00002,
    S_EV_RD   = 18'h00004,
    S_EV_CHK  = 18'h00008,
    S_PR_RD   = 18'h00010,
    S_PR_MX   = 18'h00020,
    S_PR_MY   = 18'h00040,
    S_PR_SUM  = 18'h00080,
    S_SQ      = 18'h00100,
    S_MUL_S   = 18'h00200,
    S_DIV_LD  = 18'h00400,
    S_DIV     = 18'h00800,
    S_H_RD    = 18'h01000,
    S_H_WR    = 18'h02000,
    S_INS     = 18'h04000,
    S_RO_RD   = 18'h08000,
    S_RO_LD   = 18'h10000,
    S_RO_WAIT = 18'h20000
  } state_t;

  state_t state;

  // configuration registers
  logic [RADIUS_W-1:0] radius;
  logic [BINS_W-1:0]   bins_in_use;

  // per-point context
  logic signed [COORD_BITS-1:0] xi, yi;
  logic                         final_r;
  logic signed [XL_W-1:0]       xlimit;
  logic [NB_W-1:0]              nb;
  logic [P_W-1:0]               r2;

  // window control
  logic [AW-1:0]     head;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] k;
  logic              overflow;

  // shared multiplier and pair datapath
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [P_W-1:0]         prod, sqx;
  logic [MUL_W-1:0]       ady_r;
  logic [SQ_OP_W-1:0]     sq_op;
  logic [SQ_N:0]          sq_rem;
  logic [SQ_N-1:0]        sq_root;
  logic [STEP_W-1:0]      step;
  logic [P_W-1:0]         div_p;
  logic [NB_W-1:0]        div_q;
  logic [NB_W-1:0]        rb;

  // window memory ports
  logic                         win_we;
  logic [AW-1:0]                win_waddr, win_raddr;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;

  // histogram memory
  logic [COUNT_W-1:0] hist_mem [MAX_BINS];
  logic [MAX_BINS-1:0] hist_val;
  logic [COUNT_W-1:0] hist_rd;
  logic               hist_ok;
  logic [BIN_W-1:0]   hist_raddr, bin;
  logic               hist_we;
  logic [COUNT_W-1:0] hist_cur, hist_wdata;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [FILL_W-1:0] off);
    logic [AW+1:0] s;
    s = (AW+2)'(base) + (AW+2)'(off);
    if (s >= (AW+2)'(WINDOW_DEPTH)) s = s - (AW+2)'(WINDOW_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_head(input logic [AW-1:0] h);
    return (h == AW'(WINDOW_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  pdh_window_ram #(
    .DEPTH(WINDOW_DEPTH),
    .AW   (AW)
  ) u_window (
    .clk  (clk),
    .we   (win_we),
    .waddr(win_waddr),
    .wx   (xi),
    .wy   (yi),
    .raddr(win_raddr),
    .rx   (rd_x),
    .ry   (rd_y)
  );

  assign in_ready  = (state == S_IDLE);
  assign win_raddr = wrap_add(head, k);

  // pair differences from the window entry just read
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      adx, ady;
  assign dx  = (COORD_BITS+1)'(rd_x) - (COORD_BITS+1)'(xi);
  assign dy  = (COORD_BITS+1)'(rd_y) - (COORD_BITS+1)'(yi);
  assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

  logic [D2_W-1:0] d2;
  assign d2 = D2_W'(sqx) + D2_W'(prod);

  // one square root step: bring down two bits, try root*4+1
  logic [SQ_N+2:0] sq_rem2, sq_trial;
  logic            sq_fit;
  assign sq_rem2  = {sq_rem, sq_op[SQ_OP_W-1 -: 2]};
  assign sq_trial = (SQ_N+3)'({sq_root, 2'b01});
  assign sq_fit   = (sq_rem2 >= sq_trial);

  // one divide step: subtract radius shifted to the current quotient bit
  logic [P_W-1:0] div_d;
  logic           div_fit;
  assign div_d   = P_W'(radius) << step;
  assign div_fit = (div_p >= div_d);

  assign bin = (div_q >= nb) ? BIN_W'(nb - 1'b1) : BIN_W'(div_q);

  // window insert: drop the oldest entry when full
  logic              win_full;
  logic [AW-1:0]     head_ins;
  logic [FILL_W-1:0] fill_ins;
  assign win_full  = (fill >= FILL_W'(WINDOW_DEPTH));
  assign head_ins  = win_full ? inc_head(head) : head;
  assign fill_ins  = win_full ? fill - 1'b1 : fill;
  assign win_waddr = wrap_add(head_ins, fill_ins);
  assign win_we    = (state == S_INS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_R2: begin
        mul_a = MUL_W'(radius);
        mul_b = MUL_W'(radius);
      end
      S_PR_MX: begin
        mul_a = MUL_W'(adx);
        mul_b = MUL_W'(adx);
      end
      S_PR_MY: begin
        mul_a = ady_r;
        mul_b = ady_r;
      end
      S_MUL_S: begin
        mul_a = sq_root[MUL_W-1:0];
        mul_b = MUL_W'(nb);
      end
      default: begin
      end
    endcase
  end

  assign hist_raddr = (state == S_RO_RD) ? BIN_W'(rb) : bin;
  assign hist_cur   = hist_ok ? hist_rd : '0;
  assign hist_wdata = (hist_cur > COUNT_MAX - PAIR_INC) ? COUNT_MAX : hist_cur + PAIR_INC;
  assign hist_we    = (state == S_H_WR);

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[bin] <= hist_wdata;
    hist_rd <= hist_mem[hist_raddr];
    hist_ok <= hist_val[hist_raddr];
  end

  logic readout_done;
  assign readout_done = (state == S_RO_WAIT) && out_ready && (rb == nb - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || readout_done) begin
      hist_val <= '0;
    end else if (hist_we) begin
      hist_val[bin] <= 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RESET;
      bins_in_use <= BINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIUS: radius      <= cfg_data[RADIUS_W-1:0];
        CFG_BINS:   bins_in_use <= cfg_data[BINS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // shared datapath registers; no reset needed
  always_ff @(posedge clk) begin
    if (state == S_R2 || state == S_PR_MX || state == S_PR_MY || state == S_MUL_S) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_IDLE && in_valid) begin
      xi      <= in_data.pos_x;
      yi      <= in_data.pos_y;
      final_r <= in_data.final_point;
      xlimit  <= XL_W'(in_data.pos_x) - XL_W'($signed({1'b0, radius}));
      if (bins_in_use == '0) begin
        nb <= NB_W'(1);
      end else if (32'(bins_in_use) > MAX_BINS) begin
        nb <= NB_W'(MAX_BINS);
      end else begin
        nb <= NB_W'(bins_in_use);
      end
    end
    if (state == S_EV_RD) r2 <= prod;
    if (state == S_PR_MX) ady_r <= MUL_W'(ady);
    if (state == S_PR_MY) sqx <= prod;
    if (state == S_PR_SUM) begin
      sq_op   <= SQ_OP_W'(d2);
      sq_rem  <= '0;
      sq_root <= '0;
    end
    if (state == S_SQ) begin
      sq_op   <= sq_op << 2;
      sq_rem  <= sq_fit ? (SQ_N+1)'(sq_rem2 - sq_trial) : sq_rem2[SQ_N:0];
      sq_root <= {sq_root[SQ_N-2:0], sq_fit};
    end
    if (state == S_DIV_LD) begin
      div_p <= prod;
      div_q <= '0;
    end
    if (state == S_DIV) begin
      if (div_fit) div_p <= div_p - div_d;
      div_q <= NB_W'({div_q, div_fit});
    end
    if (state == S_RO_LD) begin
      out_data.bin_number        <= BIN_NUM_W'(rb);
      out_data.bin_count         <= hist_cur;
      out_data.window_overflowed <= overflow;
      out_data.last_bin          <= (rb == nb - 1'b1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      k         <= '0;
      overflow  <= 1'b0;
      step      <= '0;
      rb        <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            k     <= '0;
            state <= S_R2;
          end
        end
        S_R2: state <= S_EV_RD;
        S_EV_RD: state <= (fill == '0) ? S_PR_RD : S_EV_CHK;
        S_EV_CHK: begin
          // evict the oldest entry while it lies left of x - radius
          if (XL_W'(rd_x) < xlimit) begin
            head  <= inc_head(head);
            fill  <= fill - 1'b1;
            state <= S_EV_RD;
          end else begin
            state <= S_PR_RD;
          end
        end
        S_PR_RD: state <= (k == fill) ? S_INS : S_PR_MX;
        S_PR_MX: state <= S_PR_MY;
        S_PR_MY: state <= S_PR_SUM;
        S_PR_SUM: begin
          if (d2 < D2_W'(r2)) begin
            step  <= '0;
            state <= S_SQ;
          end else begin
            k     <= k + 1'b1;
            state <= S_PR_RD;
          end
        end
        S_SQ: begin
          step <= step + 1'b1;
          if (step == STEP_W'(SQ_N - 1)) state <= S_MUL_S;
        end
        S_MUL_S: state <= S_DIV_LD;
        S_DIV_LD: begin
          step  <= STEP_W'(NB_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          step <= step - 1'b1;
          if (step == '0) state <= S_H_RD;
        end
        S_H_RD: state <= S_H_WR;
        S_H_WR: begin
          k     <= k + 1'b1;
          state <= S_PR_RD;
        end
        S_INS: begin
          head <= head_ins;
          fill <= fill_ins + 1'b1;
          if (win_full) overflow <= 1'b1;
          rb    <= '0;
          state <= final_r ? S_RO_RD : S_IDLE;
        end
        S_RO_RD: state <= S_RO_LD;
        S_RO_LD: begin
          out_valid <= 1'b1;
          state     <= S_RO_WAIT;
        end
        S_RO_WAIT: begin
          // hold the bin until the receiver takes it
          if (out_ready) begin
            out_valid <= 1'b0;
            if (rb == nb - 1'b1) begin
              head     <= '0;
              fill     <= '0;
              overflow <= 1'b0;
              state    <= S_IDLE;
            end else begin
              rb    <= rb + 1'b1;
              state <= S_RO_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
